// File: design/lobm_pkg.sv
// ---------------------------------------------------------------------------
// lobm_pkg: shared types and codes for the order book matcher
// Operation and side codes, state encoding and fill unit control.
// ---------------------------------------------------------------------------
package lobm_pkg;

    localparam int OP_W     = 2;
    localparam int PRICE_W  = 8;
    localparam int INQTY_W  = 16;
    localparam int FILLED_W = 16;
    localparam int VALUE_W  = 24;

    localparam logic [OP_W-1:0] OP_REST   = 2'd0;
    localparam logic [OP_W-1:0] OP_MARKET = 2'd1;
    localparam logic [OP_W-1:0] OP_LIMIT  = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;   // unused, leaves the book alone

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_DROP = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_REST  = 8'b0000_0100,
        S_LVL   = 8'b0000_1000,
        S_QRD   = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_ACC   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic clear;   // zero the traded value
        logic load;    // capture fill quantity
        logic mul;     // fill times level price
        logic acc;     // add product into traded value
    } fill_ctl_t;

endpackage

// File: design/lobm_ram.sv
// ---------------------------------------------------------------------------
// lobm_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lobm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/lobm_fill_unit.sv
// ---------------------------------------------------------------------------
// lobm_fill_unit: shared fill arithmetic
// Min of remaining and resting quantity, then fill times price accumulated.
// ---------------------------------------------------------------------------
module lobm_fill_unit
    import lobm_pkg::*;
#(
    parameter int QTY_BITS = 16,
    parameter int LVL_W    = 8
) (
    input  logic                clk,
    input  fill_ctl_t           ctl,
    input  logic [QTY_BITS-1:0] rem,
    input  logic [QTY_BITS-1:0] avail,
    input  logic [LVL_W-1:0]    level,
    output logic [QTY_BITS-1:0] fill,
    output logic [QTY_BITS-1:0] left,
    output logic [VALUE_W-1:0]  value
);

    logic [QTY_BITS-1:0]       fill_reg;
    logic [QTY_BITS+LVL_W-1:0] prod_reg;
    logic [VALUE_W-1:0]        value_reg;

    assign fill  = (rem < avail) ? rem : avail;
    assign left  = avail - fill;
    assign value = value_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            fill_reg <= fill;
        end
        if (ctl.mul)
        begin
            prod_reg <= (QTY_BITS+LVL_W)'(fill_reg) * (QTY_BITS+LVL_W)'(level);
        end
        if (ctl.clear)
        begin
            value_reg <= '0;
        end
        else if (ctl.acc)
        begin
            value_reg <= value_reg + VALUE_W'(prod_reg);
        end
    end

endmodule

// File: design/limit_order_book_matcher_unit.sv
// ---------------------------------------------------------------------------
// limit_order_book_matcher_unit: price-time priority limit order book
// Two-sided book, per-level circular queues, sequenced matching engine.
// ---------------------------------------------------------------------------
// One item at a time. After reset a clearing pass zeroes the per-level
// head/count table, all 2 * 2**clog2(PRICE_LEVELS) entries (512 by
// default), during which in_ready stays low. A rest item steps through
// accept with table read, write and result. A market or limit item reads
// each price level visited from the level table and takes each resting
// order touched through read, multiply and accumulate in the shared fill
// unit, between an accept step and a result step. After the last fill the
// walk goes on past emptied levels until it finds the next populated one,
// so the new best quote is known.
// The result sits in an output register, so a new item may be taken while
// the previous result is still waiting on out_ready.
// ---------------------------------------------------------------------------
module limit_order_book_matcher_unit
    import lobm_pkg::*;
#(
    parameter int PRICE_LEVELS     = 256,
    parameter int ORDERS_PER_LEVEL = 16,
    parameter int QTY_BITS         = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic                order_side,
    input  logic [INQTY_W-1:0]  quantity,
    input  logic [PRICE_W-1:0]  price_tick,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FILLED_W-1:0] filled_qty,
    output logic [VALUE_W-1:0]  traded_value,
    output logic [PRICE_W-1:0]  best_bid,
    output logic                bid_present,
    output logic [PRICE_W-1:0]  best_ask,
    output logic                ask_present,
    output logic                status
);

    localparam int LVL_W = $clog2(PRICE_LEVELS);
    localparam int HD_W  = $clog2(ORDERS_PER_LEVEL);
    localparam int CT_W  = $clog2(ORDERS_PER_LEVEL + 1);
    localparam int LA_W  = LVL_W + 1;
    localparam int LV_DEPTH = 2 ** LA_W;
    localparam int SLOTS = PRICE_LEVELS * ORDERS_PER_LEVEL;
    localparam int Q_DEPTH = 2 * SLOTS;
    localparam int QA_W  = $clog2(Q_DEPTH);
    localparam int CMP_W = (LVL_W > PRICE_W) ? LVL_W : PRICE_W;
    localparam int RNG_W = CMP_W + 1;

    // Resting quantity address: side block, level row, queue slot.
    function automatic logic [QA_W-1:0] qaddr(
        input logic             s,
        input logic [LVL_W-1:0] l,
        input logic [HD_W-1:0]  sl
    );
        logic [QA_W-1:0] base;
        base = s ? QA_W'(SLOTS) : '0;
        return base + QA_W'(l) * QA_W'(ORDERS_PER_LEVEL) + QA_W'(sl);
    endfunction

    // Control state
    state_t            state_reg, state_next;
    logic [LA_W-1:0]   clr_reg, clr_next;
    logic [LVL_W-1:0]  best_bid_reg, best_bid_next;
    logic [LVL_W-1:0]  best_ask_reg, best_ask_next;
    logic              bid_pres_reg, bid_pres_next;
    logic              ask_pres_reg, ask_pres_next;
    logic              out_valid_reg, out_valid_next;

    // Item payload and walk state
    logic [OP_W-1:0]     op_reg, op_next;
    logic                side_reg, side_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [QTY_BITS-1:0] qty_reg, qty_next;
    logic [QTY_BITS-1:0] rem_reg, rem_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [HD_W-1:0]     hd_reg, hd_next;
    logic [CT_W-1:0]     ct_reg, ct_next;
    logic                status_reg, status_next;

    // Result register
    logic [FILLED_W-1:0] out_filled_reg, out_filled_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [PRICE_W-1:0]  out_bb_reg, out_bb_next;
    logic [PRICE_W-1:0]  out_ba_reg, out_ba_next;
    logic                out_bp_reg, out_bp_next;
    logic                out_ap_reg, out_ap_next;
    logic                out_st_reg, out_st_next;

    // Memories
    logic                 lv_we;
    logic [LA_W-1:0]      lv_waddr, lv_raddr;
    logic [HD_W+CT_W-1:0] lv_wdata, lv_rdata;
    logic [HD_W-1:0]      lv_hd;
    logic [CT_W-1:0]      lv_ct;
    logic                 q_we;
    logic [QA_W-1:0]      q_waddr, q_raddr;
    logic [QTY_BITS-1:0]  q_wdata, q_rdata;

    // Fill unit
    fill_ctl_t            fctl;
    logic [QTY_BITS-1:0]  fill, left;
    logic [VALUE_W-1:0]   value;

    // Helpers
    logic                 book;        // side being walked
    logic                 buy;         // walk ascending asks
    logic                 at_end;
    logic [LVL_W-1:0]     lvl_step;
    logic                 beyond_limit;
    logic [LVL_W-1:0]     lvl_p;
    logic [CT_W:0]        slot_sum;
    logic [HD_W-1:0]      slot;
    logic [HD_W-1:0]      hd_inc;
    logic [QTY_BITS-1:0]  qty_cut;
    logic                 out_free;

    assign lv_hd = lv_rdata[HD_W+CT_W-1:CT_W];
    assign lv_ct = lv_rdata[CT_W-1:0];

    assign book     = ~side_reg;
    assign buy      = (side_reg == SIDE_BID);
    assign at_end   = buy ? (lvl_reg == LVL_W'(PRICE_LEVELS - 1)) : (lvl_reg == '0);
    assign lvl_step = buy ? (lvl_reg + 1'b1) : (lvl_reg - 1'b1);
    assign beyond_limit = (op_reg == OP_LIMIT) &&
        (buy ? (CMP_W'(lvl_reg) > CMP_W'(price_reg))
             : (CMP_W'(lvl_reg) < CMP_W'(price_reg)));
    assign lvl_p    = LVL_W'(price_reg);
    assign slot_sum = (CT_W+1)'(lv_hd) + (CT_W+1)'(lv_ct);
    assign slot     = (slot_sum >= (CT_W+1)'(ORDERS_PER_LEVEL))
                    ? HD_W'(slot_sum - (CT_W+1)'(ORDERS_PER_LEVEL))
                    : HD_W'(slot_sum);
    assign hd_inc   = (hd_reg == HD_W'(ORDERS_PER_LEVEL - 1)) ? '0 : (hd_reg + 1'b1);
    assign qty_cut  = QTY_BITS'(quantity);
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign filled_qty   = out_filled_reg;
    assign traded_value = out_value_reg;
    assign best_bid     = out_bb_reg;
    assign bid_present  = out_bp_reg;
    assign best_ask     = out_ba_reg;
    assign ask_present  = out_ap_reg;
    assign status       = out_st_reg;

    lobm_ram #(
        .DEPTH (LV_DEPTH),
        .WIDTH (HD_W + CT_W)
    ) u_level_ram (
        .clk   (clk),
        .we    (lv_we),
        .waddr (lv_waddr),
        .wdata (lv_wdata),
        .raddr (lv_raddr),
        .rdata (lv_rdata)
    );

    lobm_ram #(
        .DEPTH (Q_DEPTH),
        .WIDTH (QTY_BITS)
    ) u_qty_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    lobm_fill_unit #(
        .QTY_BITS (QTY_BITS),
        .LVL_W    (LVL_W)
    ) u_fill (
        .clk   (clk),
        .ctl   (fctl),
        .rem   (rem_reg),
        .avail (q_rdata),
        .level (lvl_reg),
        .fill  (fill),
        .left  (left),
        .value (value)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        best_bid_next  = best_bid_reg;
        best_ask_next  = best_ask_reg;
        bid_pres_next  = bid_pres_reg;
        ask_pres_next  = ask_pres_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        qty_next       = qty_reg;
        rem_next       = rem_reg;
        lvl_next       = lvl_reg;
        hd_next        = hd_reg;
        ct_next        = ct_reg;
        status_next    = status_reg;

        out_filled_next = out_filled_reg;
        out_value_next  = out_value_reg;
        out_bb_next     = out_bb_reg;
        out_ba_next     = out_ba_reg;
        out_bp_next     = out_bp_reg;
        out_ap_next     = out_ap_reg;
        out_st_next     = out_st_reg;

        lv_we    = 1'b0;
        lv_waddr = {book, lvl_reg};
        lv_wdata = {hd_reg, ct_reg};
        lv_raddr = {book, lvl_reg};
        q_we     = 1'b0;
        q_waddr  = qaddr(book, lvl_reg, hd_reg);
        q_wdata  = left;
        q_raddr  = qaddr(book, lvl_reg, hd_reg);
        fctl     = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                lv_we    = 1'b1;
                lv_waddr = clr_reg;
                lv_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LA_W'(LV_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = operation;
                    side_next   = order_side;
                    price_next  = price_tick;
                    qty_next    = qty_cut;
                    rem_next    = qty_cut;
                    status_next = ST_OK;
                    fctl.clear  = 1'b1;
                    state_next  = S_DONE;
                    case (operation)
                        OP_REST:
                        begin
                            if (RNG_W'(price_tick) >= RNG_W'(PRICE_LEVELS))
                            begin
                                status_next = ST_DROP;
                            end
                            else if (qty_cut != '0)
                            begin
                                lv_raddr   = {order_side, LVL_W'(price_tick)};
                                state_next = S_REST;
                            end
                        end
                        OP_MARKET, OP_LIMIT:
                        begin
                            if (order_side == SIDE_BID)
                            begin
                                lvl_next = best_ask_reg;
                                if (qty_cut != '0 && ask_pres_reg)
                                begin
                                    lv_raddr   = {SIDE_ASK, best_ask_reg};
                                    state_next = S_LVL;
                                end
                            end
                            else
                            begin
                                lvl_next = best_bid_reg;
                                if (qty_cut != '0 && bid_pres_reg)
                                begin
                                    lv_raddr   = {SIDE_BID, best_bid_reg};
                                    state_next = S_LVL;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_REST:
            begin
                state_next = S_DONE;
                if (lv_ct >= CT_W'(ORDERS_PER_LEVEL))
                begin
                    status_next = ST_DROP;
                end
                else
                begin
                    q_we     = 1'b1;
                    q_waddr  = qaddr(side_reg, lvl_p, slot);
                    q_wdata  = qty_reg;
                    lv_we    = 1'b1;
                    lv_waddr = {side_reg, lvl_p};
                    lv_wdata = {lv_hd, lv_ct + 1'b1};
                    if (side_reg == SIDE_BID)
                    begin
                        if (!bid_pres_reg || lvl_p > best_bid_reg)
                        begin
                            best_bid_next = lvl_p;
                        end
                        bid_pres_next = 1'b1;
                    end
                    else
                    begin
                        if (!ask_pres_reg || lvl_p < best_ask_reg)
                        begin
                            best_ask_next = lvl_p;
                        end
                        ask_pres_next = 1'b1;
                    end
                end
            end

            S_LVL:
            begin
                hd_next = lv_hd;
                ct_next = lv_ct;
                if (lv_ct == '0)
                begin
                    // empty level: keep scanning outward
                    if (at_end)
                    begin
                        state_next = S_DONE;
                        if (book == SIDE_BID)
                        begin
                            bid_pres_next = 1'b0;
                            best_bid_next = '0;
                        end
                        else
                        begin
                            ask_pres_next = 1'b0;
                            best_ask_next = '0;
                        end
                    end
                    else
                    begin
                        lvl_next = lvl_step;
                        lv_raddr = {book, lvl_step};
                    end
                end
                else if (rem_reg == '0 || beyond_limit)
                begin
                    // populated level left standing: new best quote
                    state_next = S_DONE;
                    if (book == SIDE_BID)
                    begin
                        best_bid_next = lvl_reg;
                    end
                    else
                    begin
                        best_ask_next = lvl_reg;
                    end
                end
                else
                begin
                    q_raddr    = qaddr(book, lvl_reg, lv_hd);
                    state_next = S_QRD;
                end
            end

            S_QRD:
            begin
                fctl.load = 1'b1;
                rem_next  = rem_reg - fill;
                if (left == '0)
                begin
                    hd_next = hd_inc;
                    ct_next = ct_reg - 1'b1;
                end
                else
                begin
                    q_we = 1'b1;
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                fctl.mul   = 1'b1;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                fctl.acc = 1'b1;
                if (ct_reg != '0 && rem_reg != '0)
                begin
                    q_raddr    = qaddr(book, lvl_reg, hd_reg);
                    state_next = S_QRD;
                end
                else
                begin
                    lv_we = 1'b1;
                    if (ct_reg != '0)
                    begin
                        state_next = S_DONE;
                        if (book == SIDE_BID)
                        begin
                            best_bid_next = lvl_reg;
                        end
                        else
                        begin
                            best_ask_next = lvl_reg;
                        end
                    end
                    else if (at_end)
                    begin
                        state_next = S_DONE;
                        if (book == SIDE_BID)
                        begin
                            bid_pres_next = 1'b0;
                            best_bid_next = '0;
                        end
                        else
                        begin
                            ask_pres_next = 1'b0;
                            best_ask_next = '0;
                        end
                    end
                    else
                    begin
                        lvl_next   = lvl_step;
                        lv_raddr   = {book, lvl_step};
                        state_next = S_LVL;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_filled_next = FILLED_W'(qty_reg - rem_reg);
                    out_value_next  = value;
                    out_bb_next     = PRICE_W'(best_bid_reg);
                    out_bp_next     = bid_pres_reg;
                    out_ba_next     = PRICE_W'(best_ask_reg);
                    out_ap_next     = ask_pres_reg;
                    out_st_next     = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            best_bid_reg  <= '0;
            best_ask_reg  <= '0;
            bid_pres_reg  <= 1'b0;
            ask_pres_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            best_bid_reg  <= best_bid_next;
            best_ask_reg  <= best_ask_next;
            bid_pres_reg  <= bid_pres_next;
            ask_pres_reg  <= ask_pres_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        side_reg       <= side_next;
        price_reg      <= price_next;
        qty_reg        <= qty_next;
        rem_reg        <= rem_next;
        lvl_reg        <= lvl_next;
        hd_reg         <= hd_next;
        ct_reg         <= ct_next;
        status_reg     <= status_next;
        out_filled_reg <= out_filled_next;
        out_value_reg  <= out_value_next;
        out_bb_reg     <= out_bb_next;
        out_ba_reg     <= out_ba_next;
        out_bp_reg     <= out_bp_next;
        out_ap_reg     <= out_ap_next;
        out_st_reg     <= out_st_next;
    end

    // Checks
    a_qrd_has_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_QRD |-> ct_reg != '0)
        else $error("fill attempted on empty level");

    a_bid_quote_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !bid_pres_reg |-> best_bid_reg == '0)
        else $error("best bid nonzero with no bids");

    a_ask_quote_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !ask_pres_reg |-> best_ask_reg == '0)
        else $error("best ask nonzero with no asks");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> rem_reg <= qty_reg)
        else $error("filled more than ordered");

    a_level_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LVL |-> lv_ct <= CT_W'(ORDERS_PER_LEVEL))
        else $error("level count beyond queue depth");

endmodule

// File: tb/limit_order_book_matcher_unit_test.sv
// ---------------------------------------------------------------------------
// limit_order_book_matcher_unit_test: self-checking bench for the order book
// Drives rest, market and limit items with random idling on both channels,
// predicts every result with a software book and checks it field by field.
// ---------------------------------------------------------------------------
module limit_order_book_matcher_unit_test
    import lobm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS = 256;
    localparam int DEPTH  = 16;

    // one expected result
    typedef struct {
        logic [FILLED_W-1:0] filled;
        logic [VALUE_W-1:0]  value;
        logic [PRICE_W-1:0]  bid;
        logic                bid_p;
        logic [PRICE_W-1:0]  ask;
        logic                ask_p;
        logic                st;
    } quote_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    // Software book: per-level FIFOs on each side, plus the queue of results owed.
    class book_scoreboard;
        int unsigned bq [2][LEVELS][$];   // [side][level] -> quantities, oldest first
        quote_t      owed [$];
        int          checked;
        int          fills_seen;
        int          drops_seen;

        function void note_item(logic [OP_W-1:0] op, logic side, logic [INQTY_W-1:0] qty,
                                logic [PRICE_W-1:0] px);
            quote_t q;
            int unsigned rem;
            int unsigned f;
            int lvl;
            int opp;
            longint unsigned filled;
            longint unsigned value;
            filled = 0;
            value = 0;
            q.st = ST_OK;
            if (op == OP_REST) begin
                if (qty != 0) begin
                    if (bq[side][px].size() >= DEPTH) q.st = ST_DROP;
                    else bq[side][px].insert(bq[side][px].size(), 32'(qty));
                end
            end else if (op == OP_MARKET || op == OP_LIMIT) begin
                // buy walks asks upward, sell walks bids downward
                opp = (side == SIDE_BID) ? 1 : 0;
                rem = 32'(qty);
                for (int s = 0; s < LEVELS && rem > 0; s++) begin
                    lvl = (side == SIDE_BID) ? s : LEVELS - 1 - s;
                    if (bq[opp][lvl].size() == 0) continue;
                    if (op == OP_LIMIT && ((side == SIDE_BID) ? (lvl > px) : (lvl < px))) break;
                    while (bq[opp][lvl].size() > 0 && rem > 0) begin
                        f = (rem < bq[opp][lvl][0]) ? rem : bq[opp][lvl][0];
                        filled += f;
                        value += longint'(f) * lvl;
                        rem -= f;
                        bq[opp][lvl][0] -= f;
                        if (bq[opp][lvl][0] == 0) void'(bq[opp][lvl].pop_front());
                    end
                end
            end
            q.filled = filled[FILLED_W-1:0];
            q.value  = value[VALUE_W-1:0];
            q.bid = '0; q.bid_p = 0; q.ask = '0; q.ask_p = 0;
            for (int l = 0; l < LEVELS; l++)
                if (bq[0][l].size() > 0) begin q.bid = PRICE_W'(l); q.bid_p = 1; end
            for (int l = LEVELS - 1; l >= 0; l--)
                if (bq[1][l].size() > 0) begin q.ask = PRICE_W'(l); q.ask_p = 1; end
            if (filled != 0) fills_seen++;
            if (q.st == ST_DROP) drops_seen++;
            owed.insert(owed.size(), q);
        endfunction

        task check_result(logic [FILLED_W-1:0] fq, logic [VALUE_W-1:0] tv,
                          logic [PRICE_W-1:0] bb, logic bp, logic [PRICE_W-1:0] ba,
                          logic ap, logic st);
            quote_t w;
            if (owed.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            w = owed.pop_front();
            checked++;
            if (fq !== w.filled) report_mismatch("filled_qty", fq, w.filled);
            if (tv !== w.value)  report_mismatch("traded_value", tv, w.value);
            if (bb !== w.bid)    report_mismatch("best_bid", bb, w.bid);
            if (bp !== w.bid_p)  report_mismatch("bid_present", bp, w.bid_p);
            if (ba !== w.ask)    report_mismatch("best_ask", ba, w.ask);
            if (ap !== w.ask_p)  report_mismatch("ask_present", ap, w.ask_p);
            if (st !== w.st)     report_mismatch("status", st, w.st);
        endtask
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                in_valid = 0;
    logic                in_ready;
    logic [OP_W-1:0]     operation = OP_REST;
    logic                order_side = SIDE_BID;
    logic [INQTY_W-1:0]  quantity = '0;
    logic [PRICE_W-1:0]  price_tick = '0;
    logic                out_valid;
    logic                out_ready = 0;
    logic [FILLED_W-1:0] filled_qty;
    logic [VALUE_W-1:0]  traded_value;
    logic [PRICE_W-1:0]  best_bid;
    logic                bid_present;
    logic [PRICE_W-1:0]  best_ask;
    logic                ask_present;
    logic                status;

    book_scoreboard sb = new();
    bit             calm = 0;   // no idling on either side while set
    int             sent = 0;

    limit_order_book_matcher_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .order_side(order_side),
        .quantity(quantity), .price_tick(price_tick),
        .out_valid(out_valid), .out_ready(out_ready),
        .filled_qty(filled_qty), .traded_value(traded_value),
        .best_bid(best_bid), .bid_present(bid_present),
        .best_ask(best_ask), .ask_present(ask_present),
        .status(status)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Result side: random stalls, checks on every accepted result.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(filled_qty, traded_value, best_bid, bid_present,
                                best_ask, ask_present, status);
            out_ready <= calm || ($urandom_range(99) >= 18);
        end
    end

    // Presents one item, with an optional idle gap first, and waits for acceptance.
    task automatic send_item(input logic [OP_W-1:0] op, input logic side,
                             input logic [INQTY_W-1:0] qty, input logic [PRICE_W-1:0] px);
        while (!calm && $urandom_range(99) < 18) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid   <= 1;
        operation  <= op;
        order_side <= side;
        quantity   <= qty;
        price_tick <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(op, side, qty, px);
        sent++;
    endtask

    // Mostly rests near a mid price, with matches that cross into the book.
    task automatic random_item();
        int r;
        logic [OP_W-1:0] op;
        logic [INQTY_W-1:0] q;
        logic [PRICE_W-1:0] p;
        r = $urandom_range(99);
        op = (r < 55) ? OP_REST : (r < 75) ? OP_MARKET : (r < 97) ? OP_LIMIT : OP_SPARE;
        r = $urandom_range(99);
        q = (r < 70) ? INQTY_W'($urandom_range(1, 200))
          : (r < 90) ? INQTY_W'($urandom_range(0, 65535))
          : (r < 95) ? 16'hFFFF : 16'd0;
        r = $urandom_range(99);
        p = (r < 80) ? PRICE_W'($urandom_range(112, 143)) : PRICE_W'($urandom_range(0, 255));
        send_item(op, 1'($urandom_range(1)), q, p);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, every operation, empty book, full level, bad code
        send_item(OP_MARKET, SIDE_BID, 16'd10, 8'd0);       // empty opposite side
        send_item(OP_LIMIT,  SIDE_ASK, 16'd10, 8'd255);
        send_item(OP_REST,   SIDE_BID, 16'd0,  8'd50);      // zero quantity rest
        send_item(OP_REST,   SIDE_ASK, 16'hFFFF, 8'd255);
        send_item(OP_REST,   SIDE_BID, 16'hFFFF, 8'd0);
        send_item(OP_REST,   SIDE_ASK, 16'd1, 8'd0);        // crossed book
        send_item(OP_REST,   SIDE_BID, 16'd1, 8'd255);
        for (int i = 0; i < DEPTH + 1; i++)                 // last one finds level full
            send_item(OP_REST, SIDE_ASK, 16'(i + 1), 8'd200);
        send_item(OP_SPARE,  SIDE_BID, 16'd5, 8'd200);      // unused code
        send_item(OP_MARKET, SIDE_BID, 16'd0, 8'd0);        // zero quantity match
        send_item(OP_LIMIT,  SIDE_BID, 16'd100, 8'd199);    // stops at limit
        send_item(OP_MARKET, SIDE_BID, 16'hFFFF, 8'd0);
        send_item(OP_MARKET, SIDE_ASK, 16'hFFFF, 8'd255);

        // random: a calm stretch first, then idling on both sides
        calm = 1;
        for (int i = 0; i < 200; i++) random_item();
        calm = 0;
        for (int i = 0; i < 1100; i++) random_item();
        in_valid <= 0;

        while (sb.owed.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        $display("%0d items sent, %0d results checked, %0d with fills, %0d rests dropped",
                 sent, sb.checked, sb.fills_seen, sb.drops_seen);
        if (errors == 0 && sb.owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

endmodule

// File: limit_order_book_matcher_unit.f
design/lobm_pkg.sv
design/lobm_ram.sv
design/lobm_fill_unit.sv
design/limit_order_book_matcher_unit.sv
tb/limit_order_book_matcher_unit_test.sv
